>>> design/convex_hull_perimeter_top_assert.svh
// Assertion macros for the convex hull perimeter block.
`ifndef CONVEX_HULL_PERIMETER_TOP_ASSERT_SVH
`define CONVEX_HULL_PERIMETER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CHP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/chp_pkg.sv
// Shared constants and types of the convex hull perimeter block.
package chp_pkg;
    localparam int MAX_POINTS = 1024;
    localparam int FRAC_BITS  = 8;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int COORD_W    = 19;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SQ_W       = PROD_W;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int SQRT_CNT_W = $clog2(ROOT_W);
    localparam int SUM_W      = 22;
    localparam int PERIM_W    = 21;
    localparam int VERT_W     = 11;
    localparam int WORD_W     = 2 * COORD_W + 1;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [SUM_W-1:0] PERIM_MAX = SUM_W'({PERIM_W{1'b1}});

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] radicand;
    } chp_sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } chp_sqrt_rsp_t;
endpackage

>>> design/chp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module chp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> design/chp_isqrt.sv
// Floor integer square root, two radicand bits per cycle.
module chp_isqrt
    import chp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  chp_sqrt_req_t req,
    output chp_sqrt_rsp_t rsp
);
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SQ_W-1:0]       n_reg, n_next;
    logic [ROOT_W:0]       rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [ROOT_W+2:0]     rem_sh;
    logic [ROOT_W+2:0]     trial;

    assign rem_sh = {rem_reg, n_reg[SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            n_next    = req.radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            n_next = {n_reg[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = (ROOT_W+1)'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SQRT_CNT_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;
endmodule

>>> design/convex_hull_perimeter_top.sv
// Convex hull perimeter by gift wrapping: top level with sequencer and shared multiplier.
//
// Points (signed Q.8 x/y) stream in one per cycle and are written to a
// 1024-entry point RAM; points beyond capacity are dropped and reported
// through m_overflow. The item flagged s_last_point starts the walk and
// s_ready stays low until the result is registered. The walk first scans
// all n stored points for the start vertex, then for each hull vertex
// scans every point through one shared 20x20 multiplier; a point already
// on the hull (other than the start) is skipped after its read. Each
// edge length then comes from the 20-step square root unit. The result
// waits in an output register, so a new set may load while it is still
// pending.
module convex_hull_perimeter_top
    import chp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_x_coord,
    input  logic signed [COORD_W-1:0] s_y_coord,
    input  logic                      s_last_point,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [PERIM_W-1:0]        m_perimeter,
    output logic [VERT_W-1:0]         m_hull_vertices,
    output logic                      m_overflow
);
`include "convex_hull_perimeter_top_assert.svh"

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_FIND_RD  = 5'd1;
    localparam logic [4:0] S_FIND_CMP = 5'd2;
    localparam logic [4:0] S_VTX      = 5'd3;
    localparam logic [4:0] S_RD       = 5'd4;
    localparam logic [4:0] S_DAT      = 5'd5;
    localparam logic [4:0] S_C1       = 5'd6;
    localparam logic [4:0] S_C2       = 5'd7;
    localparam logic [4:0] S_C3       = 5'd8;
    localparam logic [4:0] S_L2       = 5'd9;
    localparam logic [4:0] S_L3       = 5'd10;
    localparam logic [4:0] S_END      = 5'd11;
    localparam logic [4:0] S_E1       = 5'd12;
    localparam logic [4:0] S_E2       = 5'd13;
    localparam logic [4:0] S_E3       = 5'd14;
    localparam logic [4:0] S_SQ       = 5'd15;
    localparam logic [4:0] S_OUT      = 5'd16;

    logic [4:0]                state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      dropped_reg, dropped_next;
    logic [ADDR_W-1:0]         idx_reg, idx_next;
    logic [ADDR_W-1:0]         start_idx_reg, start_idx_next;
    logic [ADDR_W-1:0]         cur_idx_reg, cur_idx_next;
    logic [ADDR_W-1:0]         best_idx_reg, best_idx_next;
    logic signed [COORD_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [COORD_W-1:0] curx_reg, curx_next, cury_reg, cury_next;
    logic signed [COORD_W-1:0] bestx_reg, bestx_next, besty_reg, besty_next;
    logic signed [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [DIFF_W-1:0]  ax_reg, ax_next, ay_reg, ay_next;
    logic signed [DIFF_W-1:0]  bx_reg, bx_next, by_reg, by_next;
    logic signed [PROD_W-1:0]  prod_reg, p1_reg, p1_next;
    logic signed [PROD_W:0]    cross_reg, cross_next;
    logic [SQ_W-1:0]           best_sq_reg, best_sq_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [CNT_W-1:0]          vcount_reg, vcount_next;
    logic                      close_reg, close_next;
    logic                      m_valid_reg, m_valid_next;
    logic [PERIM_W-1:0]        perim_reg, perim_next;
    logic [VERT_W-1:0]         verts_reg, verts_next;
    logic                      ovf_reg, ovf_next;

    logic signed [DIFF_W-1:0]  mul_a, mul_b;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [WORD_W-1:0]         ram_wdata, ram_rdata;
    logic signed [COORD_W-1:0] rd_x, rd_y;
    logic                      rd_hull;
    logic                      in_acc, last_idx, take, sel, close_now;
    logic [SQ_W-1:0]           sq_sum;
    logic [SUM_W:0]            sum_wide;
    chp_sqrt_req_t             sqrt_req;
    chp_sqrt_rsp_t             sqrt_rsp;

    chp_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_points (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    chp_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .rsp     (sqrt_rsp)
    );

    assign rd_x    = ram_rdata[COORD_W-1:0];
    assign rd_y    = ram_rdata[2*COORD_W-1:COORD_W];
    assign rd_hull = ram_rdata[2*COORD_W];

    assign s_ready  = (state_reg == S_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign last_idx = (CNT_W'(idx_reg) + 1'b1) == count_reg;
    assign sq_sum   = SQ_W'($unsigned(p1_reg)) + SQ_W'($unsigned(prod_reg));
    assign take     = (idx_reg == '0) || (rd_y < sy_reg) || ((rd_y == sy_reg) && (rd_x > sx_reg));
    assign sel      = (cross_reg > 0) || ((cross_reg == 0) && (sq_sum > best_sq_reg));
    assign close_now = (best_idx_reg == start_idx_reg) || (best_idx_reg == cur_idx_reg)
                       || (vcount_reg >= count_reg);
    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(sqrt_rsp.root);

    // Shared multiplier operand select.
    always_comb begin
        unique case (state_reg)
            S_C1:    begin mul_a = ax_reg; mul_b = by_reg; end
            S_C2:    begin mul_a = bx_reg; mul_b = ay_reg; end
            S_C3:    begin mul_a = ax_reg; mul_b = ax_reg; end
            S_L2:    begin mul_a = ay_reg; mul_b = ay_reg; end
            S_E1:    begin mul_a = ax_reg; mul_b = ax_reg; end
            default: begin mul_a = ay_reg; mul_b = ay_reg; end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        idx_next       = idx_reg;
        start_idx_next = start_idx_reg;
        cur_idx_next   = cur_idx_reg;
        best_idx_next  = best_idx_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        curx_next      = curx_reg;
        cury_next      = cury_reg;
        bestx_next     = bestx_reg;
        besty_next     = besty_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        p1_next        = p1_reg;
        cross_next     = cross_reg;
        best_sq_next   = best_sq_reg;
        sum_next       = sum_reg;
        vcount_next    = vcount_reg;
        close_next     = close_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        perim_next     = perim_reg;
        verts_next     = verts_reg;
        ovf_next       = ovf_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[ADDR_W-1:0];
        ram_wdata      = {1'b0, s_y_coord, s_x_coord};
        sqrt_req.start    = 1'b0;
        sqrt_req.radicand = sq_sum;

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    // Store the point, or drop it when the store is full.
                    if (count_reg < CNT_W'(MAX_POINTS)) begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_last_point) begin
                        idx_next    = '0;
                        sum_next    = '0;
                        vcount_next = '0;
                        state_next  = S_FIND_RD;
                    end
                end
            end
            S_FIND_RD: state_next = S_FIND_CMP;
            S_FIND_CMP: begin
                // Lowest y, then largest x; earliest point wins full ties.
                if (take) begin
                    start_idx_next = idx_reg;
                    sx_next        = rd_x;
                    sy_next        = rd_y;
                end
                if (last_idx) begin
                    cur_idx_next = take ? idx_reg : start_idx_reg;
                    curx_next    = take ? rd_x : sx_reg;
                    cury_next    = take ? rd_y : sy_reg;
                    state_next   = S_VTX;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_VTX: begin
                // Mark the vertex visited and reset the candidate.
                ram_we        = 1'b1;
                ram_waddr     = cur_idx_reg;
                ram_wdata     = {1'b1, cury_reg, curx_reg};
                vcount_next   = vcount_reg + 1'b1;
                best_idx_next = cur_idx_reg;
                bestx_next    = curx_reg;
                besty_next    = cury_reg;
                bx_next       = '0;
                by_next       = '0;
                best_sq_next  = '0;
                idx_next      = '0;
                state_next    = S_RD;
            end
            S_RD: state_next = S_DAT;
            S_DAT: begin
                if (rd_hull && (idx_reg != start_idx_reg)) begin
                    if (last_idx) begin
                        state_next = S_END;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end else begin
                    px_next    = rd_x;
                    py_next    = rd_y;
                    ax_next    = DIFF_W'(rd_x) - DIFF_W'(curx_reg);
                    ay_next    = DIFF_W'(rd_y) - DIFF_W'(cury_reg);
                    state_next = S_C1;
                end
            end
            S_C1: state_next = S_C2;
            S_C2: begin
                p1_next    = prod_reg;
                state_next = S_C3;
            end
            S_C3: begin
                cross_next = (PROD_W+1)'(p1_reg) - (PROD_W+1)'(prod_reg);
                state_next = S_L2;
            end
            S_L2: begin
                p1_next    = prod_reg;
                state_next = S_L3;
            end
            S_L3: begin
                // Keep the more clockwise point, or the farther collinear one.
                if (sel) begin
                    best_idx_next = idx_reg;
                    bestx_next    = px_reg;
                    besty_next    = py_reg;
                    bx_next       = ax_reg;
                    by_next       = ay_reg;
                    best_sq_next  = sq_sum;
                end
                if (last_idx) begin
                    state_next = S_END;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_END: begin
                close_next = close_now;
                if (close_now) begin
                    ax_next = DIFF_W'(sx_reg) - DIFF_W'(curx_reg);
                    ay_next = DIFF_W'(sy_reg) - DIFF_W'(cury_reg);
                end else begin
                    ax_next = bx_reg;
                    ay_next = by_reg;
                end
                state_next = S_E1;
            end
            S_E1: state_next = S_E2;
            S_E2: begin
                p1_next    = prod_reg;
                state_next = S_E3;
            end
            S_E3: begin
                sqrt_req.start = 1'b1;
                state_next     = S_SQ;
            end
            S_SQ: begin
                if (sqrt_rsp.done) begin
                    sum_next = (sum_wide > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
                    if (close_reg) begin
                        state_next = S_OUT;
                    end else begin
                        cur_idx_next = best_idx_reg;
                        curx_next    = bestx_reg;
                        cury_next    = besty_reg;
                        state_next   = S_VTX;
                    end
                end
            end
            S_OUT: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    perim_next   = (sum_reg > PERIM_MAX) ? PERIM_W'(PERIM_MAX)
                                                         : sum_reg[PERIM_W-1:0];
                    verts_next   = VERT_W'(vcount_reg);
                    ovf_next     = dropped_reg;
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            vcount_reg  <= '0;
            sum_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
            vcount_reg  <= vcount_next;
            sum_reg     <= sum_next;
        end
        idx_reg       <= idx_next;
        start_idx_reg <= start_idx_next;
        cur_idx_reg   <= cur_idx_next;
        best_idx_reg  <= best_idx_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        curx_reg      <= curx_next;
        cury_reg      <= cury_next;
        bestx_reg     <= bestx_next;
        besty_reg     <= besty_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        bx_reg        <= bx_next;
        by_reg        <= by_next;
        prod_reg      <= mul_a * mul_b;
        p1_reg        <= p1_next;
        cross_reg     <= cross_next;
        best_sq_reg   <= best_sq_next;
        close_reg     <= close_next;
        perim_reg     <= perim_next;
        verts_reg     <= verts_next;
        ovf_reg       <= ovf_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_perimeter     = perim_reg;
    assign m_hull_vertices = verts_reg;
    assign m_overflow      = ovf_reg;

    `CHP_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CNT_W'(MAX_POINTS),
        "point count beyond store capacity")
    `CHP_ASSERT_NEXT(a_last_blocks, in_acc && s_last_point, !s_ready,
        "input taken while hull walk runs")
    `CHP_ASSERT_NOW(a_vcount_cap, state_reg != S_IDLE, vcount_reg <= count_reg,
        "vertex count beyond point count")
    `CHP_ASSERT_NOW(a_sqrt_wait, sqrt_rsp.done, state_reg == S_SQ,
        "square root result outside its wait state")
endmodule
